@@ rtl/core/ffra_pkg.sv @@
// Shared constants, payload types and controller/datapath signal groups.
`default_nettype none

package ffra_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [31:0] PAGE_LOW_MASK  = 32'h0000_0fff;
    localparam logic [31:0] PAGE_HIGH_MASK = 32'hffff_f000;
    localparam logic [31:0] PAGE_BYTES     = 32'h0000_1000;
    localparam logic [31:0] LIMIT_RESET    = 32'h1000_0000;

    localparam int          PADDR_W        = 3;
    localparam logic [0:0]  REG_IDX_LIMIT  = 1'b0;

    localparam logic        CMD_LOAD       = 1'b0;
    localparam logic        CMD_ALLOC      = 1'b1;
    localparam logic        STATUS_OK      = 1'b0;
    localparam logic        STATUS_NO_FIT  = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic        command;
        logic [3:0]  entry_index;
        logic [31:0] region_start;
        logic [31:0] region_end;
        logic [31:0] request_size;
    } t_in_word;

    typedef struct packed {
        logic [31:0] block_address;
        logic        status;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic fit;
        logic last;
        logic out_free;
    } t_ctrl_stat;

    function automatic logic [31:0] round_to_page(input logic [31:0] size);
        logic [31:0] res;
        res = size;
        if ((size & PAGE_LOW_MASK) != 32'd0) begin
            res = (size & PAGE_HIGH_MASK) + PAGE_BYTES;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ffra_ctrl.sv @@
// Controller state machine: sequences capture, table scan and result commit.
`default_nettype none

module ffra_ctrl
    import ffra_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_ctrl_stat i_stat,
    output t_ctrl_cmd       o_cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_BUSY = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_BUSY;
                end
            end
            S_BUSY: begin
                if (i_stat.is_load || i_stat.fit || i_stat.last) begin
                    // hold until the output register can take the word
                    if (i_stat.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ffra_dpath.sv @@
// Datapath: region table, item registers, scan compare and output register.
`default_nettype none

module ffra_dpath
    import ffra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in_word    i_in_word,
    input  wire logic [31:0] i_region_limit,
    input  wire t_ctrl_cmd   i_cmd,
    output t_ctrl_stat       o_stat,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word
);

    logic [31:0]              r_free_start [TABLE_ENTRIES];
    logic [31:0]              r_free_end   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic        r_cmd;
    t_idx        r_slot;
    logic        r_slot_ok;
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [31:0] r_size;
    t_idx        r_cnt;

    logic        r_out_valid;
    t_out_word   r_out_word;

    logic [31:0] ent_start;
    logic [31:0] ent_end;
    logic [31:0] ent_len;
    logic        exact;
    logic        larger;
    logic        commit_alloc;

    // an entry that was never loaded, or was used up exactly, reads as zero
    assign ent_start = r_valid[r_cnt] ? r_free_start[r_cnt] : 32'd0;
    assign ent_end   = r_valid[r_cnt] ? r_free_end[r_cnt]   : 32'd0;
    assign ent_len   = ent_end - ent_start;
    assign exact     = (ent_len == r_size);
    assign larger    = (ent_len > r_size);

    assign o_stat.is_load  = (r_cmd == CMD_LOAD);
    assign o_stat.fit      = exact || larger;
    assign o_stat.last     = (r_cnt == t_idx'(TABLE_ENTRIES - 1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign commit_alloc = i_cmd.finish && (r_cmd == CMD_ALLOC) && (exact || larger);

    // item capture and scan counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd     <= i_in_word.command;
            r_slot    <= t_idx'(i_in_word.entry_index);
            r_slot_ok <= (32'(i_in_word.entry_index) < 32'(TABLE_ENTRIES));
            r_start   <= i_in_word.region_start;
            r_end     <= (i_in_word.region_end >= i_region_limit) ?
                         i_region_limit : i_in_word.region_end;
            r_size    <= round_to_page(i_in_word.request_size);
            r_cnt     <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + t_idx'(1);
        end
    end

    // table contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && (r_cmd == CMD_LOAD) && r_slot_ok) begin
            r_free_start[r_slot] <= r_start;
            r_free_end[r_slot]   <= r_end;
        end else if (commit_alloc && larger) begin
            r_free_start[r_cnt] <= ent_start + r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.finish && (r_cmd == CMD_LOAD) && r_slot_ok) begin
            r_valid[r_slot] <= 1'b1;
        end else if (commit_alloc && exact) begin
            r_valid[r_cnt] <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_cmd == CMD_LOAD) begin
                r_out_word.block_address <= 32'd0;
                r_out_word.status        <= STATUS_OK;
            end else if (exact || larger) begin
                r_out_word.block_address <= ent_start;
                r_out_word.status        <= STATUS_OK;
            end else begin
                r_out_word.block_address <= 32'd0;
                r_out_word.status        <= STATUS_NO_FIT;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

@@ rtl/core/first_fit_region_allocator_top.sv @@
// Top level of the first-fit free region allocator: APB register and core.
`default_nettype none

// Channel   Direction  Handshake                 Word
// --------  ---------  ------------------------  ------------------------------
// input     in         i_in_valid / o_in_stall   t_in_word  (load or allocate)
// output    out        o_out_valid / i_out_stall t_out_word (address, status)
// config    in         psel/penable/pwrite       region_limit at byte address 0
//
// A load word is accepted, then committed to the table and answered.
// An allocate word is accepted, then the table is scanned, one table
// entry compared per cycle (one subtract and compare) until the first fit or
// the last entry. Reset empties the table at once through per-entry valid bits
// and sets region_limit to 256 MB; there is no clearing pass. The answer sits
// in an output register, so a new word is taken while it waits; the final
// step of the next word holds until that register drains.

module first_fit_region_allocator_top
    import ffra_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_word           i_in_word,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_word               o_out_word,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [31:0] r_region_limit;
    t_ctrl_cmd   cmd;
    t_ctrl_stat  stat;
    logic        limit_hit;

    // register index is the word address; low byte-lane bits are ignored
    assign limit_hit = (paddr[PADDR_W-1:2] == REG_IDX_LIMIT);
    assign pready    = 1'b1;
    assign prdata    = limit_hit ? r_region_limit : 32'd0;

    // write on the access phase; writes beyond the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && limit_hit) begin
            r_region_limit <= pwdata;
        end
    end

    ffra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ffra_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_word      (i_in_word),
        .i_region_limit (r_region_limit),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_word     (o_out_word)
    );

endmodule

`default_nettype wire
